// ===== rtl/core/itoa_pkg.sv =====
// Shared constants, types and helpers for the integer to decimal ASCII block.
// Used by every module of the block and by its checker; depends on nothing.
package itoa_pkg;

  localparam int unsigned VALUE_WIDTH = 32;
  // Decimal digits of the largest magnitude, 2^(VALUE_WIDTH-1).
  localparam int unsigned NUM_DIGITS  = ((VALUE_WIDTH - 1) * 301) / 1000 + 1;
  localparam int unsigned BCD_WIDTH   = 4 * NUM_DIGITS;
  localparam int unsigned CNT_WIDTH   = $clog2(VALUE_WIDTH);
  localparam int unsigned DIG_WIDTH   = $clog2(NUM_DIGITS);

  localparam logic [7:0] CHAR_ZERO  = 8'd48;
  localparam logic [7:0] CHAR_NINE  = 8'd57;
  localparam logic [7:0] CHAR_MINUS = 8'd45;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_CONV = 3'b010,
    ST_EMIT = 3'b100
  } state_e;

  typedef struct packed {
    logic load;
    logic shift_bin;
    logic shift_dig;
  } bcd_ctrl_t;

  typedef struct packed {
    logic sign;
    logic digit;
    logic final_digit;
  } emit_ctrl_t;

  // Shift-and-add-3 correction of one BCD digit.
  function automatic logic [3:0] add3(input logic [3:0] d);
    logic [3:0] r;
    r = (d >= 4'd5) ? d + 4'd3 : d;
    return r;
  endfunction

endpackage

// ===== rtl/core/itoa_bcd.sv =====
// Binary to BCD converter: one magnitude bit enters per cycle, then the BCD
// register shifts one digit out per cycle. Depends on itoa_pkg.
module itoa_bcd (
  input  logic                              clk_i,
  input  itoa_pkg::bcd_ctrl_t               ctrl_i,
  input  logic [itoa_pkg::VALUE_WIDTH-1:0]  mag_i,
  output logic [3:0]                        digit_o
);
  import itoa_pkg::*;

  logic [VALUE_WIDTH-1:0] bin_q, bin_d;
  logic [BCD_WIDTH-1:0]   bcd_q, bcd_d;
  logic [BCD_WIDTH-1:0]   adj;

  always_comb begin
    for (int i = 0; i < NUM_DIGITS; i++) begin
      adj[4*i +: 4] = add3(bcd_q[4*i +: 4]);
    end
  end

  always_comb begin
    bin_d = bin_q;
    bcd_d = bcd_q;
    if (ctrl_i.load) begin
      bin_d = mag_i;
      bcd_d = '0;
    end else if (ctrl_i.shift_bin) begin
      bin_d = {bin_q[VALUE_WIDTH-2:0], 1'b0};
      bcd_d = {adj[BCD_WIDTH-2:0], bin_q[VALUE_WIDTH-1]};
    end else if (ctrl_i.shift_dig) begin
      bcd_d = {bcd_q[BCD_WIDTH-5:0], 4'b0000};
    end
  end

  always_ff @(posedge clk_i) begin
    bin_q <= bin_d;
    bcd_q <= bcd_d;
  end

  assign digit_o = bcd_q[BCD_WIDTH-1 -: 4];

endmodule

// ===== rtl/core/itoa_emit.sv =====
// Character emitter: suppresses leading zeros and registers each character.
// Depends on itoa_pkg.
module itoa_emit (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  itoa_pkg::emit_ctrl_t  ctrl_i,
  input  logic [3:0]            digit_i,
  output logic [7:0]            text_char_o,
  output logic                  last_o,
  output logic                  char_valid_o
);
  import itoa_pkg::*;

  logic       seen_q, seen_d;
  logic       valid_q, valid_d;
  logic [7:0] char_q, char_d;
  logic       last_q, last_d;
  logic       show;

  // The final digit is always shown, so zero prints as a single '0'.
  assign show = ctrl_i.digit && (seen_q || (digit_i != 4'd0) || ctrl_i.final_digit);

  always_comb begin
    seen_d  = seen_q;
    valid_d = 1'b0;
    char_d  = char_q;
    last_d  = last_q;
    if (ctrl_i.sign) begin
      valid_d = 1'b1;
      char_d  = CHAR_MINUS;
      last_d  = 1'b0;
    end else if (ctrl_i.digit) begin
      seen_d  = !ctrl_i.final_digit && show;
      valid_d = show;
      char_d  = CHAR_ZERO + {4'b0000, digit_i};
      last_d  = ctrl_i.final_digit;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q  <= 1'b0;
      valid_q <= 1'b0;
    end else begin
      seen_q  <= seen_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    char_q <= char_d;
    last_q <= last_d;
  end

  assign text_char_o  = char_q;
  assign last_o       = last_q;
  assign char_valid_o = valid_q;

endmodule

// ===== rtl/core/int_to_decimal_ascii.sv =====
// Top level of the signed integer to decimal ASCII converter: sequencer and
// magnitude logic. Depends on itoa_pkg, itoa_bcd and itoa_emit.
//
//   channel  | handshake            | payload
//   ---------+----------------------+----------------------------
//   input    | start, busy          | value_i
//   result   | char_valid_o strobe  | text_char_o, last_o
//
// An item is loaded, then its magnitude bits pass one by one through the
// shift-and-add-3 register, and then its BCD digits shift out one by one,
// leading zeros included. A minus sign appears in the cycle after acceptance;
// each character shows for exactly one cycle. Reset is asynchronous and clears
// the sequencer and the strobe. The receiver cannot stall the result stream.
module int_to_decimal_ascii (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    start,
  output logic                                    busy,
  input  logic signed [itoa_pkg::VALUE_WIDTH-1:0] value_i,
  output logic [7:0]                              text_char_o,
  output logic                                    last_o,
  output logic                                    char_valid_o
);
  import itoa_pkg::*;

  state_e               state_q, state_d;
  logic [CNT_WIDTH-1:0] cnt_q, cnt_d;
  logic [DIG_WIDTH-1:0] dig_q, dig_d;
  logic                 accept;
  logic                 negative;
  logic [VALUE_WIDTH-1:0] mag;
  logic [3:0]           digit;
  bcd_ctrl_t            bcd_ctrl;
  emit_ctrl_t           emit_ctrl;

  assign accept   = start && !busy;
  assign negative = value_i[VALUE_WIDTH-1];
  // Taken unsigned, so the most negative value yields 2^(VALUE_WIDTH-1).
  assign mag      = negative ? (~value_i + 1'b1) : value_i;

  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    dig_d    = dig_q;
    bcd_ctrl = '0;
    emit_ctrl = '0;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          bcd_ctrl.load  = 1'b1;
          emit_ctrl.sign = negative;
          cnt_d   = '0;
          state_d = ST_CONV;
        end
      end
      ST_CONV: begin
        bcd_ctrl.shift_bin = 1'b1;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CNT_WIDTH'(VALUE_WIDTH - 1)) begin
          dig_d   = '0;
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        bcd_ctrl.shift_dig    = 1'b1;
        emit_ctrl.digit       = 1'b1;
        emit_ctrl.final_digit = (dig_q == DIG_WIDTH'(NUM_DIGITS - 1));
        dig_d = dig_q + 1'b1;
        if (emit_ctrl.final_digit) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      dig_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      dig_q   <= dig_d;
    end
  end

  assign busy = (state_q != ST_IDLE);

  itoa_bcd u_bcd (
    .clk_i   (clk_i),
    .ctrl_i  (bcd_ctrl),
    .mag_i   (mag),
    .digit_o (digit)
  );

  itoa_emit u_emit (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_i       (emit_ctrl),
    .digit_i      (digit),
    .text_char_o  (text_char_o),
    .last_o       (last_o),
    .char_valid_o (char_valid_o)
  );

endmodule

// ===== rtl/core/itoa_checker.sv =====
// Port-level checker for int_to_decimal_ascii, attached by the bind below.
// Depends on itoa_pkg.
module itoa_checker (
  input logic                                    clk_i,
  input logic                                    rst_ni,
  input logic                                    start,
  input logic                                    busy,
  input logic signed [itoa_pkg::VALUE_WIDTH-1:0] value_i,
  input logic [7:0]                              text_char_o,
  input logic                                    last_o,
  input logic                                    char_valid_o
);
  import itoa_pkg::*;

  // An accepted item keeps the block busy in the next cycle.
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("block not busy after an accepted item");

  // Every character is a minus sign or a decimal digit.
  a_char_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    char_valid_o |-> (text_char_o == CHAR_MINUS) ||
                     ((text_char_o >= CHAR_ZERO) && (text_char_o <= CHAR_NINE)))
    else $error("character outside the decimal alphabet");

  // A negative item starts its text with a minus sign that is never final.
  a_sign_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && value_i[VALUE_WIDTH-1]) |=>
      char_valid_o && (text_char_o == CHAR_MINUS) && !last_o)
    else $error("missing leading minus sign");

  // The block goes idle exactly as the final character of an item shows.
  a_done_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> char_valid_o && last_o)
    else $error("item finished without a final character");

endmodule

bind int_to_decimal_ascii itoa_checker u_itoa_checker (.*);

// ===== tb/tb.sv =====
// Self-checking bench for int_to_decimal_ascii: drives integers through the
// start/busy handshake and checks every ASCII character against a predictor.
// Depends on itoa_pkg and the int_to_decimal_ascii RTL.
module tb;
  import itoa_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned DRAIN_CYCLES = 60;
  localparam int unsigned RANDOM_ITEMS = 140;
  localparam int unsigned QUIET_ITEMS = 40;
  localparam int unsigned MAX_REPORTS = 10;

  typedef struct {
    logic [7:0] ch;
    logic       last;
  } text_char_t;

  class decimal_text_board;
    text_char_t expected_chars[$];
    int         mismatches;

    function new();
      mismatches = 0;
    endfunction

    // Magnitude is taken unsigned so the most negative value prints in full.
    function void note_value(logic signed [VALUE_WIDTH-1:0] value);
      logic [VALUE_WIDTH-1:0] mag;
      logic [3:0]             digits[$];
      text_char_t             c;
      mag = value[VALUE_WIDTH-1] ? (~value + 1'b1) : value;
      do begin
        digits.push_front(4'(mag % 10));
        mag = mag / 10;
      end while (mag != 0);
      if (value[VALUE_WIDTH-1]) begin
        c.ch = CHAR_MINUS;
        c.last = 1'b0;
        expected_chars.push_back(c);
      end
      foreach (digits[i]) begin
        c.ch = CHAR_ZERO + 8'(digits[i]);
        c.last = (i == digits.size() - 1);
        expected_chars.push_back(c);
      end
    endfunction

    function void check_char(logic [7:0] ch, logic last);
      text_char_t want;
      if (expected_chars.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected character: char=%0d last=%0b", ch, last);
        return;
      end
      want = expected_chars.pop_front();
      if (ch !== want.ch || last !== want.last) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("character mismatch: expected char=%0d last=%0b, got char=%0d last=%0b",
                   want.ch, want.last, ch, last);
      end
    endfunction

    function int pending();
      return expected_chars.size();
    endfunction
  endclass

  logic                          clk_i;
  logic                          rst_ni;
  logic                          start;
  logic                          busy;
  logic signed [VALUE_WIDTH-1:0] value_i;
  logic [7:0]                    text_char_o;
  logic                          last_o;
  logic                          char_valid_o;

  decimal_text_board board;
  int unsigned       cycles;

  int_to_decimal_ascii u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .value_i     (value_i),
    .text_char_o (text_char_o),
    .last_o      (last_o),
    .char_valid_o(char_valid_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Items are taken when start is high and busy is low at the rising edge.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start && !busy) board.note_value(value_i);
      if (char_valid_o) board.check_char(text_char_o, last_o);
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Holds one item on the inputs until it is taken. With gaps enabled, start
  // drops now and then for a short burst, at any phase of the conversion.
  task automatic send_value(input logic signed [VALUE_WIDTH-1:0] value, input bit gaps);
    int hold;
    hold = (gaps && $urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
    forever begin
      @(negedge clk_i);
      if (hold > 0) begin
        start <= 1'b0;
        value_i <= $urandom;
        hold--;
      end else begin
        start <= 1'b1;
        value_i <= value;
      end
      @(posedge clk_i);
      if (start && !busy) break;
      if (gaps && hold == 0 && $urandom_range(0, 15) == 0) hold = $urandom_range(1, 3);
    end
  endtask

  function automatic logic signed [VALUE_WIDTH-1:0] random_value();
    longint pow;
    logic signed [VALUE_WIDTH-1:0] v;
    pow = 1;
    case ($urandom_range(0, 4))
      0, 1: v = $urandom;
      2: begin
        v = $urandom_range(0, 99999);
        if ($urandom_range(0, 1)) v = -v;
      end
      3: begin
        // Around a power of ten, where the digit count changes.
        repeat ($urandom_range(0, 9)) pow = pow * 10;
        v = VALUE_WIDTH'(pow + $urandom_range(0, 2) - 1);
        if ($urandom_range(0, 1)) v = -v;
      end
      default: begin
        v = {1'b1, {(VALUE_WIDTH-1){1'b0}}} + $urandom_range(0, 3);
        if ($urandom_range(0, 1)) v = v - 4 - $urandom_range(0, 3);
      end
    endcase
    return v;
  endfunction

  initial begin
    logic signed [VALUE_WIDTH-1:0] directed[$];
    board = new();
    cycles = 0;
    rst_ni = 1'b0;
    start = 1'b0;
    value_i = '0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    directed = '{0, 1, -1, 9, -9, 10, -10, 99, -100, 7,
                 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0001,
                 1000000000, -1000000000, 999999999, 1234567890,
                 32'sh5555_5555, 32'shAAAA_AAAA, 32'shFFFF_FFF6};
    foreach (directed[i]) send_value(directed[i], 1'b1);

    for (int n = 0; n < RANDOM_ITEMS; n++)
      send_value(random_value(), n < RANDOM_ITEMS - QUIET_ITEMS);

    @(negedge clk_i);
    start <= 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (board.mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
